// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL module tksd_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/tksd_pkg.sv =====
package tksd_pkg;

   localparam int KEY_W       = 8;
   localparam int STAMP_W     = 32;
   localparam int ACTION_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int LENGTH_W    = 4;

   localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMBO_KEYS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMBO_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMBO_WINDOW = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE      = 2'd3;

   localparam logic [STAMP_W-1:0] MAX_AGE_RESET = 32'd1000;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] combo_keys;
      logic [LENGTH_W-1:0]   combo_length;
      logic [STAMP_W-1:0]    combo_window;
      logic [STAMP_W-1:0]    max_age;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

// ===== sv/tksd_mem.sv =====
module tksd_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  tksd_pkg::entry_type wr_entry,
   input  logic [ADDR_W-1:0]   rd_addr,
   output tksd_pkg::entry_type rd_entry
);

   tksd_pkg::entry_type store_ff [DEPTH];
   tksd_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= store_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== sv/tksd_seq.sv =====
`include "assert_macros.svh"

module tksd_seq #(
   parameter int HISTORY_DEPTH = 16,
   parameter int MAX_SEQUENCE  = 8,
   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
   localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tksd_pkg::cfg_type                   cfg,
   input  logic                                start,
   output logic                                busy,
   input  logic [tksd_pkg::ACTION_W-1:0]       req_action,
   input  logic [tksd_pkg::KEY_W-1:0]          req_key_code,
   input  logic [tksd_pkg::STAMP_W-1:0]        req_stamp,
   input  logic [tksd_pkg::STAMP_W-1:0]        req_elapsed,
   output logic                                rsp_strobe,
   output logic                                rsp_combo_found,
   output logic [CW-1:0]                       rsp_entry_count,
   output logic                                rsp_oldest_dropped,
   output logic                                mem_wr_en,
   output logic [IW-1:0]                       mem_wr_addr,
   output tksd_pkg::entry_type                 mem_wr_entry,
   output logic [IW-1:0]                       mem_rd_addr,
   input  tksd_pkg::entry_type                 mem_rd_entry
);

   localparam int WW = $clog2(MAX_SEQUENCE + 1);
   localparam int LW = tksd_pkg::LENGTH_W;
   localparam int SW = tksd_pkg::STAMP_W;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_APPLY     = 3'd1;
   localparam logic [2:0] S_PRUNE_RD  = 3'd2;
   localparam logic [2:0] S_PRUNE_CHK = 3'd3;
   localparam logic [2:0] S_SCAN      = 3'd4;
   localparam logic [2:0] S_FINISH    = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;
   logic [SW-1:0] clock_ticks_ff, clock_ticks_in;
   logic [IW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0] issue_cnt_ff, issue_cnt_in;
   logic [CW-1:0] cmp_cnt_ff, cmp_cnt_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [WW-1:0] want_ff, want_in;
   logic          dropped_ff, dropped_in;
   logic          found_ff, found_in;
   logic          strobe_ff, strobe_in;
   logic [SW-1:0] first_ff, first_in;
   logic [SW-1:0] last_ff, last_in;

   logic [tksd_pkg::ACTION_W-1:0] action_ff;
   logic [tksd_pkg::KEY_W-1:0]    key_ff;
   logic [SW-1:0]                 stamp_ff;
   logic [SW-1:0]                 elapsed_ff;

   logic [LW-1:0]              len_eff;
   logic [CW:0]                wsum;
   logic [IW-1:0]              wslot;
   logic                       full;
   logic [SW:0]                tick_sum;
   logic [SW:0]                age;
   logic                       too_old;
   logic [SW:0]                span;
   logic                       span_ok;
   logic [tksd_pkg::KEY_W-1:0] target;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] slot);
      return (slot == IW'(HISTORY_DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   assign len_eff  = (cfg.combo_length > LW'(MAX_SEQUENCE)) ? LW'(MAX_SEQUENCE)
                                                            : cfg.combo_length;
   assign full     = (held_ff == CW'(HISTORY_DEPTH));
   assign wsum     = (CW + 1)'(oldest_ff) + (CW + 1)'(held_ff);
   assign wslot    = (wsum >= (CW + 1)'(HISTORY_DEPTH))
                     ? IW'(wsum - (CW + 1)'(HISTORY_DEPTH)) : IW'(wsum);
   assign tick_sum = {1'b0, clock_ticks_ff} + {1'b0, elapsed_ff};
   assign age      = {1'b0, clock_ticks_ff} - {1'b0, mem_rd_entry.stamp};
   assign too_old  = !age[SW] && (age[SW-1:0] > cfg.max_age);
   assign span     = {1'b0, last_ff} - {1'b0, first_ff};
   assign span_ok  = span[SW] || (span[SW-1:0] < cfg.combo_window);
   assign target   = tksd_pkg::KEY_W'(cfg.combo_keys >> {want_ff, 3'b000});

   always_comb begin
      state_in       = state_ff;
      oldest_in      = oldest_ff;
      held_in        = held_ff;
      clock_ticks_in = clock_ticks_ff;
      scan_ptr_in    = scan_ptr_ff;
      issue_cnt_in   = issue_cnt_ff;
      cmp_cnt_in     = cmp_cnt_ff;
      rd_valid_in    = 1'b0;
      want_in        = want_ff;
      dropped_in     = dropped_ff;
      found_in       = found_ff;
      strobe_in      = 1'b0;
      first_in       = first_ff;
      last_in        = last_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = full ? oldest_ff : wslot;
      mem_wr_entry   = '{key: key_ff, stamp: stamp_ff};
      mem_rd_addr    = (state_ff == S_SCAN) ? scan_ptr_ff : oldest_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dropped_in = 1'b0;
               state_in   = S_APPLY;
            end
         end
         S_APPLY: begin
            case (action_ff)
               tksd_pkg::ACT_PRESS: begin
                  mem_wr_en = 1'b1;
                  if (full) begin
                     oldest_in  = next_slot(oldest_ff);
                     dropped_in = 1'b1;
                  end else begin
                     held_in = held_ff + 1'b1;
                  end
               end
               tksd_pkg::ACT_ADVANCE: begin
                  clock_ticks_in = tick_sum[SW] ? '1 : tick_sum[SW-1:0];
               end
               tksd_pkg::ACT_CLEAR: begin
                  held_in = '0;
               end
               default: begin
               end
            endcase
            state_in = S_PRUNE_RD;
         end
         S_PRUNE_RD: begin
            if (held_ff == '0) begin
               scan_ptr_in  = oldest_ff;
               issue_cnt_in = '0;
               cmp_cnt_in   = '0;
               want_in      = '0;
               state_in     = S_SCAN;
            end else begin
               state_in = S_PRUNE_CHK;
            end
         end
         S_PRUNE_CHK: begin
            if (too_old) begin
               oldest_in = next_slot(oldest_ff);
               held_in   = held_ff - 1'b1;
               state_in  = S_PRUNE_RD;
            end else begin
               scan_ptr_in  = oldest_ff;
               issue_cnt_in = '0;
               cmp_cnt_in   = '0;
               want_in      = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_cnt_ff != held_ff) begin
               scan_ptr_in  = next_slot(scan_ptr_ff);
               issue_cnt_in = issue_cnt_ff + 1'b1;
               rd_valid_in  = 1'b1;
            end
            if (rd_valid_ff) begin
               cmp_cnt_in = cmp_cnt_ff + 1'b1;
               if ((LW'(want_ff) < len_eff) && (mem_rd_entry.key == target)) begin
                  if (want_ff == '0) begin
                     first_in = mem_rd_entry.stamp;
                  end
                  last_in = mem_rd_entry.stamp;
                  want_in = want_ff + 1'b1;
               end
            end
            if (cmp_cnt_ff == held_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            found_in  = (len_eff != '0) && (LW'(want_ff) == len_eff) && span_ok;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         oldest_ff      <= '0;
         held_ff        <= '0;
         clock_ticks_ff <= '0;
         scan_ptr_ff    <= '0;
         issue_cnt_ff   <= '0;
         cmp_cnt_ff     <= '0;
         rd_valid_ff    <= 1'b0;
         want_ff        <= '0;
         dropped_ff     <= 1'b0;
         found_ff       <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         oldest_ff      <= oldest_in;
         held_ff        <= held_in;
         clock_ticks_ff <= clock_ticks_in;
         scan_ptr_ff    <= scan_ptr_in;
         issue_cnt_ff   <= issue_cnt_in;
         cmp_cnt_ff     <= cmp_cnt_in;
         rd_valid_ff    <= rd_valid_in;
         want_ff        <= want_in;
         dropped_ff     <= dropped_in;
         found_ff       <= found_in;
         strobe_ff      <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff  <= last_in;
      if ((state_ff == S_IDLE) && start) begin
         action_ff  <= req_action;
         key_ff     <= req_key_code;
         stamp_ff   <= req_stamp;
         elapsed_ff <= req_elapsed;
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_combo_found    = found_ff;
   assign rsp_entry_count    = held_ff;
   assign rsp_oldest_dropped = dropped_ff;

   `ASSERT_ALWAYS(a_held_in_range, clock, reset, held_ff <= CW'(HISTORY_DEPTH))
   `ASSERT_IMPLY(a_want_in_range, clock, reset, state_ff == S_SCAN, LW'(want_ff) <= len_eff)
   `ASSERT_IMPLY(a_scan_complete, clock, reset, state_ff == S_FINISH, cmp_cnt_ff == held_ff)
   `ASSERT_NEXT(a_start_takes, clock, reset, start && !busy, busy && !rsp_strobe)
   `ASSERT_NEXT(a_strobe_single, clock, reset, strobe_ff, !strobe_ff)

endmodule

// ===== sv/timed_key_sequence_detector.sv =====
// Detects a configured key sequence in a short, age-limited history of key presses.
// Request channel: an item (req_action, req_key_code, req_stamp, req_elapsed) is taken
// at a rising edge with start high and busy low. A key press appends a word to the
// history, a time advance moves the tick clock on (saturating), a clear empties it.
// Result channel: rsp_strobe is high for exactly one cycle per item, with
// rsp_combo_found, rsp_entry_count and rsp_oldest_dropped valid in that cycle.
// The receiver cannot hold results off; each result is taken in its strobe cycle.
// After an item is taken the block applies it, prunes entries older than max_age from
// the oldest on, scans the held entries for the sequence and registers the result.
// The history lives in a one-port-write, one-port-read memory with registered read
// data; pruning reads and then checks the oldest entry, one entry at a time, and the
// match scan streams one entry per cycle. One item is in work at a time, and start is
// taken again in the strobe cycle. Configuration is written through csr_write_en,
// csr_index and csr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Reset empties the history, zeroes the tick
// clock and sets the registers to their reset values; no clearing pass is needed.
module timed_key_sequence_detector #(
   parameter int HISTORY_DEPTH = 16,
   parameter int MAX_SEQUENCE  = 8,
   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
   localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [tksd_pkg::ACTION_W-1:0]      req_action,
   input  logic [tksd_pkg::KEY_W-1:0]         req_key_code,
   input  logic [tksd_pkg::STAMP_W-1:0]       req_stamp,
   input  logic [tksd_pkg::STAMP_W-1:0]       req_elapsed,
   output logic                               rsp_strobe,
   output logic                               rsp_combo_found,
   output logic [CW-1:0]                      rsp_entry_count,
   output logic                               rsp_oldest_dropped,
   input  logic                               csr_write_en,
   input  logic [tksd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tksd_pkg::CSR_DATA_W-1:0]    csr_data
);

   tksd_pkg::cfg_type   cfg_ff, cfg_in;
   logic                mem_wr_en;
   logic [IW-1:0]       mem_wr_addr;
   tksd_pkg::entry_type mem_wr_entry;
   logic [IW-1:0]       mem_rd_addr;
   tksd_pkg::entry_type mem_rd_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tksd_pkg::CSR_COMBO_KEYS:   cfg_in.combo_keys = csr_data;
            tksd_pkg::CSR_COMBO_LENGTH: cfg_in.combo_length = csr_data[tksd_pkg::LENGTH_W-1:0];
            tksd_pkg::CSR_COMBO_WINDOW: cfg_in.combo_window = csr_data[tksd_pkg::STAMP_W-1:0];
            tksd_pkg::CSR_MAX_AGE:      cfg_in.max_age = csr_data[tksd_pkg::STAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.combo_keys   <= '0;
         cfg_ff.combo_length <= '0;
         cfg_ff.combo_window <= '0;
         cfg_ff.max_age      <= tksd_pkg::MAX_AGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tksd_seq #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_SEQUENCE  (MAX_SEQUENCE)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_key_code       (req_key_code),
      .req_stamp          (req_stamp),
      .req_elapsed        (req_elapsed),
      .rsp_strobe         (rsp_strobe),
      .rsp_combo_found    (rsp_combo_found),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_oldest_dropped (rsp_oldest_dropped),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_entry       (mem_wr_entry),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_entry       (mem_rd_entry)
   );

   tksd_mem #(
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (IW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry)
   );

endmodule

// ===== verif/timed_key_sequence_detector_tb.sv =====
`timescale 1ns / 100ps

module timed_key_sequence_detector_tb;

   localparam int HISTORY_DEPTH = 16;
   localparam int MAX_SEQUENCE  = 8;
   localparam logic [tksd_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic       combo_found;
      logic [4:0] entry_count;
      logic       oldest_dropped;
   } verdict_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [tksd_pkg::ACTION_W-1:0]    req_action;
   logic [tksd_pkg::KEY_W-1:0]       req_key_code;
   logic [tksd_pkg::STAMP_W-1:0]     req_stamp;
   logic [tksd_pkg::STAMP_W-1:0]     req_elapsed;
   logic                             rsp_strobe;
   logic                             rsp_combo_found;
   logic [4:0]                       rsp_entry_count;
   logic                             rsp_oldest_dropped;
   logic                             csr_write_en;
   logic [tksd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tksd_pkg::CSR_DATA_W-1:0]  csr_data;

   tksd_pkg::cfg_type   settings;
   tksd_pkg::entry_type history[$];
   logic [31:0]         tick_count;
   verdict_type         pending_verdicts[$];

   int unsigned idle_pct;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned match_count;
   int unsigned drop_count;
   int unsigned setting_count;
   int unsigned error_count;

   timed_key_sequence_detector dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_key_code       (req_key_code),
      .req_stamp          (req_stamp),
      .req_elapsed        (req_elapsed),
      .rsp_strobe         (rsp_strobe),
      .rsp_combo_found    (rsp_combo_found),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_oldest_dropped (rsp_oldest_dropped),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic verdict_type predict_verdict(
         input logic [tksd_pkg::ACTION_W-1:0] action,
         input logic [tksd_pkg::KEY_W-1:0] key,
         input logic [tksd_pkg::STAMP_W-1:0] stamp,
         input logic [tksd_pkg::STAMP_W-1:0] elapsed);
      verdict_type         v;
      tksd_pkg::entry_type e;
      logic [32:0]         sum;
      int                  seq_len;
      int                  want;
      logic [31:0]         first_stamp;
      logic [31:0]         last_stamp;
      v = '0;
      first_stamp = '0;
      last_stamp = '0;
      case (action)
         tksd_pkg::ACT_PRESS: begin
            if (history.size() == HISTORY_DEPTH) begin
               void'(history.pop_front());
               v.oldest_dropped = 1'b1;
            end
            e.key = key;
            e.stamp = stamp;
            history.push_back(e);
         end
         tksd_pkg::ACT_ADVANCE: begin
            sum = {1'b0, tick_count} + {1'b0, elapsed};
            tick_count = sum[32] ? '1 : sum[31:0];
         end
         tksd_pkg::ACT_CLEAR: begin
            history.delete();
         end
         default: ;
      endcase
      while (history.size() != 0 &&
             $signed({2'b00, tick_count}) - $signed({2'b00, history[0].stamp}) >
             $signed({2'b00, settings.max_age}))
         void'(history.pop_front());
      seq_len = (settings.combo_length > MAX_SEQUENCE) ? MAX_SEQUENCE : settings.combo_length;
      want = 0;
      foreach (history[i]) begin
         if (want < seq_len && history[i].key == settings.combo_keys[8 * want +: 8]) begin
            if (want == 0)
               first_stamp = history[i].stamp;
            last_stamp = history[i].stamp;
            want++;
         end
      end
      v.combo_found = seq_len != 0 && want == seq_len &&
                      $signed({2'b00, last_stamp}) - $signed({2'b00, first_stamp}) <
                      $signed({2'b00, settings.combo_window});
      v.entry_count = 5'(history.size());
      return v;
   endfunction

   task automatic send_word(input logic [tksd_pkg::ACTION_W-1:0] action,
                            input logic [tksd_pkg::KEY_W-1:0] key,
                            input logic [tksd_pkg::STAMP_W-1:0] stamp,
                            input logic [tksd_pkg::STAMP_W-1:0] elapsed);
      int unsigned gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 48) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= action;
      req_key_code <= key;
      req_stamp    <= stamp;
      req_elapsed  <= elapsed;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      pending_verdicts.push_back(predict_verdict(action, key, stamp, elapsed));
      items_sent++;
   endtask

   task automatic await_idle();
      start <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_detector(input logic [63:0] keys_in, input logic [3:0] length_in,
                                   input logic [31:0] window_in, input logic [31:0] age_in);
      logic [tksd_pkg::CSR_INDEX_W-1:0] index_list [4];
      logic [tksd_pkg::CSR_DATA_W-1:0]  data_list [4];
      index_list = '{tksd_pkg::CSR_COMBO_KEYS, tksd_pkg::CSR_COMBO_LENGTH,
                     tksd_pkg::CSR_COMBO_WINDOW, tksd_pkg::CSR_MAX_AGE};
      data_list[0] = keys_in;
      data_list[1] = {$urandom, $urandom};
      data_list[1][tksd_pkg::LENGTH_W-1:0] = length_in;
      data_list[2] = {$urandom, $urandom};
      data_list[2][tksd_pkg::STAMP_W-1:0] = window_in;
      data_list[3] = {$urandom, $urandom};
      data_list[3][tksd_pkg::STAMP_W-1:0] = age_in;
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= index_list[i];
         csr_data     <= data_list[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      settings.combo_keys   = keys_in;
      settings.combo_length = length_in;
      settings.combo_window = window_in;
      settings.max_age      = age_in;
      setting_count++;
   endtask

   task automatic test_reset_defaults();
      send_word(tksd_pkg::ACT_PRESS, 8'h00, 32'd0, $urandom);
      send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'd1000);
      send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'd1);
   endtask

   task automatic test_history_edges();
      await_idle();
      program_detector('1, 4'd2, '1, '1);
      send_word(tksd_pkg::ACT_PRESS, 8'hFF, 32'hFFFF_FFFF, $urandom);
      send_word(tksd_pkg::ACT_PRESS, 8'hFF, 32'h0000_0000, $urandom);
      send_word(ACT_UNUSED, 8'($urandom), $urandom, $urandom);
      send_word(tksd_pkg::ACT_CLEAR, 8'($urandom), $urandom, $urandom);
   endtask

   task automatic test_pruning_shield();
      await_idle();
      program_detector(64'h03_02_01, 4'd3, 32'd10, 32'd5);
      send_word(tksd_pkg::ACT_PRESS, 8'h01, tick_count, $urandom);
      send_word(tksd_pkg::ACT_PRESS, 8'h02, tick_count - 32'd100, $urandom);
      send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'd6);
   endtask

   task automatic test_greedy_window();
      logic [31:0] t;
      t = tick_count;
      // The first key is taken at its earliest press, so the span is ten and misses.
      send_word(tksd_pkg::ACT_PRESS, 8'h01, t, $urandom);
      send_word(tksd_pkg::ACT_PRESS, 8'h01, t + 32'd3, $urandom);
      send_word(tksd_pkg::ACT_PRESS, 8'h02, t + 32'd5, $urandom);
      send_word(tksd_pkg::ACT_PRESS, 8'h03, t + 32'd10, $urandom);
   endtask

   task automatic test_overlong_sequence();
      logic [31:0] t;
      await_idle();
      program_detector(64'h08_07_06_05_04_03_02_01, 4'd15, '1, 32'd5);
      t = tick_count;
      for (int k = 1; k <= MAX_SEQUENCE; k++)
         send_word(tksd_pkg::ACT_PRESS, 8'(k), t, $urandom);
   endtask

   task automatic run_traffic(input int unsigned count);
      int unsigned first_item;
      int          seq_len;
      int          j;
      int          pick;
      longint      base;
      longint      span;
      longint      win;
      longint      stamp_at;
      logic [7:0]  noise_key;
      first_item = items_sent;
      while (items_sent - first_item < count) begin
         if ($urandom_range(99) < 70) begin
            seq_len = (settings.combo_length > MAX_SEQUENCE) ?
                      MAX_SEQUENCE : settings.combo_length;
            if (seq_len == 0)
               seq_len = $urandom_range(1, MAX_SEQUENCE);
            win = settings.combo_window;
            base = tick_count;
            base = base + $urandom_range(0, 40) - 20;
            case ($urandom_range(5))
               0: span = win - 1;
               1: span = win;
               2: span = win + 1;
               3: span = $urandom_range(0, 2000);
               4: begin
                  span = $urandom_range(0, 50);
                  span = -span;
               end
               default: span = $urandom_range(0, 300);
            endcase
            for (j = 0; j < seq_len; j++) begin
               if ($urandom_range(99) < 25) begin
                  pick = $urandom_range(7);
                  noise_key = $urandom_range(1) ? settings.combo_keys[8 * pick +: 8]
                                                : 8'($urandom);
                  stamp_at = base + $urandom_range(0, 300);
                  send_word(tksd_pkg::ACT_PRESS, noise_key, stamp_at[31:0], $urandom);
               end
               if ($urandom_range(99) < 10)
                  send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom,
                            $urandom_range(0, 200));
               if ($urandom_range(99) < 92) begin
                  stamp_at = (seq_len == 1) ? base : base + span * j / (seq_len - 1);
                  send_word(tksd_pkg::ACT_PRESS, settings.combo_keys[8 * j +: 8],
                            stamp_at[31:0], $urandom);
               end
            end
         end else begin
            case ($urandom_range(19))
               0:       send_word(tksd_pkg::ACT_CLEAR, 8'($urandom), $urandom, $urandom);
               1:       send_word(ACT_UNUSED, 8'($urandom), $urandom, $urandom);
               2, 3, 4: send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom,
                                  $urandom_range(0, 3000));
               5:       send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'd0);
               6:       send_word(tksd_pkg::ACT_PRESS, 8'($urandom), $urandom, $urandom);
               default: send_word(tksd_pkg::ACT_PRESS, 8'($urandom),
                                  tick_count - $urandom_range(0, 3000), $urandom);
            endcase
         end
         if ($urandom_range(99) < 2)
            await_idle();
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0] key_byte;
      key_byte = 8'($urandom);
      await_idle();
      program_detector({$urandom, $urandom}, 4'd4, 32'd300, 32'd3000);
      idle_pct = 0;
      run_traffic(220);
      await_idle();
      program_detector({$urandom, $urandom}, 4'd8, 32'd2000, 32'd5000);
      idle_pct = 57;
      run_traffic(220);
      await_idle();
      program_detector({$urandom, $urandom}, 4'd1, 32'd1, 32'd100);
      idle_pct = 28;
      run_traffic(220);
      await_idle();
      program_detector({8{key_byte}}, 4'd15, '1, '1);
      idle_pct = 57;
      run_traffic(220);
      await_idle();
      program_detector({$urandom, $urandom}, 4'd0, 32'd500, 32'd0);
      idle_pct = 0;
      run_traffic(220);
      await_idle();
      program_detector({$urandom, $urandom}, 4'd3, 32'd0, 32'd1000);
      idle_pct = 28;
      run_traffic(220);
   endtask

   task automatic test_clock_saturation();
      await_idle();
      idle_pct = 0;
      send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'h8000_0000);
      send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'hFFFF_FFFF);
      send_word(tksd_pkg::ACT_ADVANCE, 8'($urandom), $urandom, 32'd1);
      send_word(tksd_pkg::ACT_PRESS, 8'h5A, 32'hFFFF_FFFF, $urandom);
   endtask

   always @(posedge clock) begin : result_check
      verdict_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $error("result word arrived with no item outstanding");
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            results_seen++;
            if (want.combo_found)
               match_count++;
            if (want.oldest_dropped)
               drop_count++;
            if (rsp_combo_found !== want.combo_found) begin
               $error("combo_found: expected %0b, got %0b", want.combo_found, rsp_combo_found);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_entry_count);
               error_count++;
            end
            if (rsp_oldest_dropped !== want.oldest_dropped) begin
               $error("oldest_dropped: expected %0b, got %0b", want.oldest_dropped,
                      rsp_oldest_dropped);
               error_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_action   <= tksd_pkg::ACT_PRESS;
      req_key_code <= '0;
      req_stamp    <= '0;
      req_elapsed  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= tksd_pkg::CSR_COMBO_KEYS;
      csr_data     <= '0;
      settings.combo_keys   = '0;
      settings.combo_length = '0;
      settings.combo_window = '0;
      settings.max_age      = tksd_pkg::MAX_AGE_RESET;
      tick_count    = '0;
      idle_pct      = 0;
      items_sent    = 0;
      results_seen  = 0;
      match_count   = 0;
      drop_count    = 0;
      setting_count = 0;
      error_count   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_history_edges();
      test_pruning_shield();
      test_greedy_window();
      test_overlong_sequence();
      test_random_traffic();
      test_clock_saturation();
      await_idle();
      repeat (60) @(posedge clock);
      $display("Sent %0d words under %0d register settings and checked %0d results.",
               items_sent, setting_count, results_seen);
      $display("Results included %0d sequence matches and %0d capacity drops.",
               match_count, drop_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
